/* sv/gbn_pkg.sv */
// Shared types and constants for the go-back-n sender.
// No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PAYLOAD_MAX_DEF  = 512;
    localparam int SEQ_BITS_DEF     = 32;
    localparam logic [2:0] END_RETRY_LIMIT = 3'd3;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_PKT    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] PKT_DATA  = 2'd0;
    localparam logic [1:0] PKT_ACK   = 2'd1;
    localparam logic [1:0] PKT_END   = 2'd2;
    localparam logic [1:0] PKT_OTHER = 2'd3;

    localparam logic [2:0] KIND_DATA = 3'd0;
    localparam logic [2:0] KIND_END  = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_FAIL = 3'd3;
    localparam logic [2:0] KIND_OVF  = 3'd4;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [0:0] REG_WINDOW  = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_FILL_RD, S_FILL, S_END, S_DONE, S_RS_RD, S_RESEND, S_FAIL
    } t_state;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [1:0]  cmd;
        logic        is_ack;
        logic        tick_fire;
        logic [31:0] ack_seq;
        logic [31:0] handle;
        logic [9:0]  len;
    } t_cmd;
endpackage

/* sv/gbn_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* sv/gbn_front.sv */
// Front end: accepts commands, runs the tick counter, queues classified beats.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_front
    import gbn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_pkt_type,
    input  logic [31:0] i_ack_seq,
    input  logic [31:0] i_chunk_handle,
    input  logic [9:0]  i_chunk_len,
    input  logic [15:0] i_timeout,
    input  logic        i_finished,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);
    // Two-entry queue between front and back.
    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [15:0] r_ticks, n_ticks;
    logic [15:0] w_limit;
    logic        w_acc, w_push;
    t_cmd        w_c;

    assign o_ready = (r_cnt != 2'd2);
    assign w_acc   = i_valid && o_ready;
    assign w_limit = (i_timeout == 16'd0) ? 16'd1 : i_timeout;

    always_comb begin
        n_ticks = r_ticks + 16'd1;
        w_c.cmd       = i_cmd;
        w_c.is_ack    = (i_pkt_type == PKT_ACK);
        w_c.tick_fire = (n_ticks >= w_limit);
        w_c.ack_seq   = i_ack_seq;
        w_c.handle    = i_chunk_handle;
        w_c.len       = (i_chunk_len > 10'(PAYLOAD_MAX_DEF)) ? 10'(PAYLOAD_MAX_DEF)
                                                            : i_chunk_len;
    end

    // Finished sessions drop everything; tick counter only moves while running.
    assign w_push = w_acc && !i_finished
                    && (i_cmd == CMD_SUBMIT || i_cmd == CMD_TICK
                        || (i_cmd == CMD_PKT && i_pkt_type == PKT_ACK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_ticks <= 16'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_c;
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
            if (w_acc && !i_finished && i_cmd == CMD_TICK) begin
                r_ticks <= w_c.tick_fire ? 16'd0 : n_ticks;
            end
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
endmodule

/* sv/gbn_back.sv */
// Back end: window and pending queue bookkeeping, result sequencing.
// Depends on gbn_pkg and gbn_ram.
`timescale 1ns / 1ps
module gbn_back
    import gbn_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic [3:0]  i_window,
    output logic        o_finished,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_seq,
    output logic [31:0] o_handle,
    output logic [9:0]  o_len,
    output logic        o_last
);
    localparam int WB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int EW = 43; // is_end, len, handle

    t_state r_state, n_state;
    logic [SEQ_BITS-1:0] r_base, n_base, r_next, n_next, r_end_seq, n_end_seq;
    logic [WB-1:0] r_whead, n_whead;
    logic [WB:0]   r_wcnt, n_wcnt, r_ri, n_ri, w_ws;
    logic [QB-1:0] r_qhead, n_qhead;
    logic [QB:0]   r_qcnt, n_qcnt;
    logic r_end_pend, n_end_pend;
    logic [2:0] r_retries, n_retries;
    logic [1:0] r_status, n_status;
    t_cmd r_cur;
    logic r_ov, n_ov;
    logic [2:0]  r_kind, n_kind;
    logic [31:0] r_seq, n_seq, r_hdl, n_hdl;
    logic [9:0]  r_len, n_len;
    logic        r_last, n_last;

    logic [EW-1:0] w_wr_data, w_wrd, w_qrd;
    logic w_win_we, w_q_we;
    logic [WB-1:0] w_win_wa, w_win_ra;
    logic [QB-1:0] w_q_wa;
    logic w_emit_ok;
    logic [SEQ_BITS-1:0] w_ack, w_cur_ack;
    logic w_hit, w_fill_ok, w_more_fill, w_done_due;

    function automatic logic [WB-1:0] wadd(input logic [WB-1:0] a, input logic [WB:0] b);
        logic [WB+1:0] s;
        s = {2'b0, a} + {1'b0, b};
        if (s >= (WB+2)'(WINDOW_DEPTH)) s = s - (WB+2)'(WINDOW_DEPTH);
        return s[WB-1:0];
    endfunction
    function automatic logic [QB-1:0] qadd(input logic [QB-1:0] a, input logic [QB:0] b);
        logic [QB+1:0] s;
        s = {2'b0, a} + {1'b0, b};
        if (s >= (QB+2)'(QUEUE_DEPTH)) s = s - (QB+2)'(QUEUE_DEPTH);
        return s[QB-1:0];
    endfunction

    assign w_ws = (i_window == 4'd0) ? (WB+1)'(1)
                : ({28'd0, i_window} > 32'(WINDOW_DEPTH)) ? (WB+1)'(WINDOW_DEPTH)
                : (WB+1)'(i_window);
    assign w_ack      = i_cmd.ack_seq[SEQ_BITS-1:0];
    assign w_cur_ack  = r_cur.ack_seq[SEQ_BITS-1:0];
    assign w_emit_ok  = !r_ov || i_ready;
    assign o_finished = (r_status != ST_RUN);

    assign w_hit       = (r_wcnt != '0) && (w_ack == r_base);
    assign w_fill_ok   = (r_qcnt != '0) && (r_wcnt < w_ws);
    assign w_more_fill = (r_qcnt > (QB+1)'(1)) && ((r_wcnt + (WB+1)'(1)) < w_ws);
    assign w_done_due  = r_end_pend && (w_cur_ack == r_end_seq);

    // Window is read at head + index while resending; queue always reads its head.
    assign w_win_ra = wadd(r_whead, r_ri);

    gbn_ram #(.WIDTH(EW), .DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk(i_clk), .i_we(w_win_we), .i_waddr(w_win_wa), .i_wdata(w_wr_data),
        .i_raddr(w_win_ra), .o_rdata(w_wrd));
    gbn_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_q (
        .i_clk(i_clk), .i_we(w_q_we), .i_waddr(w_q_wa),
        .i_wdata({1'b0, i_cmd.len, i_cmd.handle}), .i_raddr(r_qhead), .o_rdata(w_qrd));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_emit_ok && r_status == ST_RUN) begin
                    if (i_cmd.cmd == CMD_PKT && i_cmd.is_ack && w_hit) begin
                        n_state = S_FILL_RD;
                    end else if (i_cmd.cmd == CMD_TICK && i_cmd.tick_fire) begin
                        n_state = S_RS_RD;
                    end
                end
            end
            S_FILL_RD: n_state = S_FILL;
            S_FILL: begin
                if (!w_fill_ok) begin
                    n_state = S_END;
                end else if (w_emit_ok) begin
                    n_state = S_FILL_RD;
                end
            end
            S_END: begin
                if (w_emit_ok || r_end_pend || r_wcnt != '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_emit_ok || !w_done_due) n_state = S_IDLE;
            end
            S_RS_RD: n_state = (r_ri < r_wcnt) ? S_RESEND : S_FAIL;
            S_RESEND: begin
                if (w_emit_ok) n_state = S_RS_RD;
            end
            S_FAIL: begin
                if (w_emit_ok || !r_end_pend || r_retries < END_RETRY_LIMIT) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result register control.
    always_comb begin
        n_base = r_base; n_next = r_next; n_end_seq = r_end_seq;
        n_whead = r_whead; n_wcnt = r_wcnt; n_ri = r_ri;
        n_qhead = r_qhead; n_qcnt = r_qcnt;
        n_end_pend = r_end_pend; n_retries = r_retries; n_status = r_status;
        n_ov = r_ov && !i_ready;
        n_kind = r_kind; n_seq = r_seq; n_hdl = r_hdl; n_len = r_len; n_last = r_last;
        o_cmd_pop = 1'b0;
        w_win_we = 1'b0; w_q_we = 1'b0;
        w_win_wa = wadd(r_whead, r_wcnt);
        w_q_wa = qadd(r_qhead, r_qcnt);
        w_wr_data = {1'b0, i_cmd.len, i_cmd.handle};
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_emit_ok) begin
                    o_cmd_pop = 1'b1;
                    n_ri = '0;
                    // Drop everything once the session has ended.
                    if (r_status == ST_RUN) begin
                        if (i_cmd.cmd == CMD_SUBMIT) begin
                            if (r_wcnt < w_ws) begin
                                w_win_we = 1'b1;
                                n_wcnt = r_wcnt + (WB+1)'(1);
                                n_next = r_next + SEQ_BITS'(1);
                                n_ov = 1'b1; n_kind = KIND_DATA; n_seq = 32'(r_next);
                                n_hdl = i_cmd.handle; n_len = i_cmd.len; n_last = 1'b1;
                            end else if (r_qcnt < (QB+1)'(QUEUE_DEPTH)) begin
                                w_q_we = 1'b1;
                                n_qcnt = r_qcnt + (QB+1)'(1);
                            end else begin
                                n_ov = 1'b1; n_kind = KIND_OVF; n_seq = '0;
                                n_hdl = i_cmd.handle; n_len = i_cmd.len; n_last = 1'b1;
                            end
                        end else if (i_cmd.cmd == CMD_PKT && i_cmd.is_ack) begin
                            if (w_hit) begin
                                // Slide now; refill reads the queue head next.
                                n_whead = wadd(r_whead, (WB+1)'(1));
                                n_wcnt = r_wcnt - (WB+1)'(1);
                                n_base = r_base + SEQ_BITS'(1);
                            end else if (r_end_pend && w_ack == r_end_seq) begin
                                n_status = ST_DONE;
                                n_ov = 1'b1; n_kind = KIND_DONE; n_seq = '0;
                                n_hdl = '0; n_len = '0; n_last = 1'b1;
                            end
                        end
                    end
                end
            end
            S_FILL: begin
                if (w_fill_ok && w_emit_ok) begin
                    w_win_we = 1'b1;
                    w_wr_data = w_qrd;
                    n_qhead = qadd(r_qhead, (QB+1)'(1));
                    n_qcnt = r_qcnt - (QB+1)'(1);
                    n_wcnt = r_wcnt + (WB+1)'(1);
                    n_next = r_next + SEQ_BITS'(1);
                    n_ov = 1'b1; n_kind = KIND_DATA; n_seq = 32'(r_next);
                    n_hdl = w_qrd[31:0]; n_len = w_qrd[41:32];
                    n_last = !w_more_fill && !w_done_due;
                end
            end
            S_END: begin
                if (!r_end_pend && r_wcnt == '0 && w_emit_ok) begin
                    w_win_we = 1'b1;
                    w_wr_data = {1'b1, 42'd0};
                    n_end_pend = 1'b1;
                    n_end_seq = r_next;
                    n_wcnt = r_wcnt + (WB+1)'(1);
                    n_next = r_next + SEQ_BITS'(1);
                    n_ov = 1'b1; n_kind = KIND_END; n_seq = 32'(r_next);
                    n_hdl = '0; n_len = '0;
                    n_last = (w_cur_ack != r_next);
                end
            end
            S_DONE: begin
                if (w_done_due && w_emit_ok) begin
                    n_status = ST_DONE;
                    n_ov = 1'b1; n_kind = KIND_DONE; n_seq = '0;
                    n_hdl = '0; n_len = '0; n_last = 1'b1;
                end
            end
            S_RESEND: begin
                if (w_emit_ok) begin
                    n_ov = 1'b1;
                    n_kind = w_wrd[42] ? KIND_END : KIND_DATA;
                    n_seq = 32'(r_base + SEQ_BITS'(r_ri));
                    n_hdl = w_wrd[42] ? 32'd0 : w_wrd[31:0];
                    n_len = w_wrd[42] ? 10'd0 : w_wrd[41:32];
                    n_last = ((r_ri + (WB+1)'(1)) == r_wcnt)
                             && !(r_end_pend && r_retries >= END_RETRY_LIMIT);
                    n_ri = r_ri + (WB+1)'(1);
                end
            end
            S_FAIL: begin
                if (r_end_pend) begin
                    if (r_retries < END_RETRY_LIMIT) begin
                        n_retries = r_retries + 3'd1;
                    end else if (w_emit_ok) begin
                        n_status = ST_FAIL;
                        n_ov = 1'b1; n_kind = KIND_FAIL; n_seq = '0;
                        n_hdl = '0; n_len = '0; n_last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= '0; r_next <= '0; r_end_seq <= '0;
            r_whead <= '0; r_wcnt <= '0; r_qhead <= '0; r_qcnt <= '0;
            r_end_pend <= 1'b0; r_retries <= 3'd0; r_status <= ST_RUN;
            r_ov <= 1'b0; r_ri <= '0;
        end else begin
            r_state <= n_state;
            r_base <= n_base; r_next <= n_next; r_end_seq <= n_end_seq;
            r_whead <= n_whead; r_wcnt <= n_wcnt; r_qhead <= n_qhead; r_qcnt <= n_qcnt;
            r_end_pend <= n_end_pend; r_retries <= n_retries; r_status <= n_status;
            r_ov <= n_ov; r_ri <= n_ri;
        end
    end

    // Result payload and the current command need no reset.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_seq  <= n_seq;
        r_hdl  <= n_hdl;
        r_len  <= n_len;
        r_last <= n_last;
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
        end
    end

    assign o_valid  = r_ov;
    assign o_kind   = r_kind;
    assign o_seq    = r_seq;
    assign o_handle = r_hdl;
    assign o_len    = r_len;
    assign o_last   = r_last;
endmodule

/* sv/go_back_n_sender.sv */
// Go-Back-N sender: a two-deep command queue feeds a window/queue engine.
// Submit: registered as a DATA result when the window has room, else queued, or OVF if full.
// Ack: slide, then FILL_RD and FILL per refill (queue RAM read), then the END and DONE states.
// Timeout: RS_RD and RESEND per resent window entry (window RAM read), then a FAIL retry check.
// A stalled result holds the engine; input is taken while fewer than two commands wait.
// Sync active-low reset clears counters, window, queue and session state; stores need none.
`timescale 1ns / 1ps
module go_back_n_sender
    import gbn_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_pkt_type,
    input  logic [31:0] i_ack_seq,
    input  logic [31:0] i_chunk_handle,
    input  logic [9:0]  i_chunk_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_out_kind,
    output logic [31:0] o_out_seq,
    output logic [31:0] o_out_handle,
    output logic [9:0]  o_out_len,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [3:0]  r_window;
    logic [15:0] r_timeout;
    logic        w_cv, w_pop, w_fin;
    t_cmd        w_c;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 4'd4;
            r_timeout <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW:  r_window <= i_cfg_data[3:0];
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gbn_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_pkt_type, .i_ack_seq,
        .i_chunk_handle, .i_chunk_len, .i_timeout(r_timeout), .i_finished(w_fin),
        .o_cmd_valid(w_cv), .o_cmd(w_c), .i_cmd_pop(w_pop));

    gbn_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH),
               .SEQ_BITS(SEQ_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .i_cmd(w_c), .o_cmd_pop(w_pop),
        .i_window(r_window), .o_finished(w_fin), .o_valid, .i_ready,
        .o_kind(o_out_kind), .o_seq(o_out_seq), .o_handle(o_out_handle),
        .o_len(o_out_len), .o_last);
endmodule

/* sv/gbn_checker.sv */
// Port-level checks for the go-back-n sender, bound to the top level.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_checker
    import gbn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_out_kind,
    input logic [31:0] o_out_seq,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_kind))
        else $error("result dropped while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_kind <= KIND_OVF) else $error("bad kind");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_DONE || o_out_kind == KIND_FAIL) |-> o_last)
        else $error("terminal result not last");
    a_zero_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_OVF |-> o_out_seq == 32'd0)
        else $error("overflow carries sequence");
endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);
